[hdl/prefix_expression_evaluator_defines.svh]
// Assertion macros for the prefix expression evaluator
`ifndef PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define PREFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define PEE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PEE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PEE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/pee_pkg.sv]
// Shared types, constants and decode functions for the prefix expression evaluator
`timescale 1ns / 1ps
package pee_pkg;
	localparam int DATA_W = 32;
	localparam int SYM_W  = 8;

	localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CHAR_SLASH = 8'h2F;

	localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic load_in;
		logic push_digit;
		logic pop;
		logic cap_left;
		logic cap_right;
		logic exec;
		logic div_start;
		logic cap_div;
		logic push_alu;
		logic read_top;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic digit;
		op_t  op;
		logic last;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic is_digit(input logic [SYM_W-1:0] sym);
		return (sym >= CHAR_ZERO) && (sym <= CHAR_NINE);
	endfunction

	function automatic op_t decode_op(input logic [SYM_W-1:0] sym);
		op_t op;
		unique case (sym)
			CHAR_PLUS:  op = OP_ADD;
			CHAR_MINUS: op = OP_SUB;
			CHAR_STAR:  op = OP_MUL;
			CHAR_SLASH: op = OP_DIV;
			default:    op = OP_NONE;
		endcase
		return op;
	endfunction
endpackage

[hdl/pee_ram.sv]
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[hdl/pee_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module pee_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pee_pkg::DATA_W-1:0] dividend,
	input  logic [pee_pkg::DATA_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic                       div_zero,
	output logic [pee_pkg::DATA_W-1:0] quotient
);
	localparam int CNT_W = $clog2(pee_pkg::DATA_W + 1);

	logic [pee_pkg::DATA_W-1:0] rem_q;
	logic [pee_pkg::DATA_W-1:0] quo_q;
	logic [pee_pkg::DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       neg_q;
	logic                       zero_q;

	logic [pee_pkg::DATA_W-1:0] abs_a;
	logic [pee_pkg::DATA_W-1:0] abs_b;
	logic [pee_pkg::DATA_W:0]   shifted;
	logic [pee_pkg::DATA_W:0]   trial;

	assign abs_a   = dividend[pee_pkg::DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b   = divisor[pee_pkg::DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
	assign shifted = {rem_q, quo_q[pee_pkg::DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (abs_b == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(pee_pkg::DATA_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= (abs_b == '0) ? '0 : abs_a;
			dvs_q  <= abs_b;
			neg_q  <= dividend[pee_pkg::DATA_W-1] ^ divisor[pee_pkg::DATA_W-1];
			zero_q <= (abs_b == '0);
		end else if (busy_q) begin
			if (!trial[pee_pkg::DATA_W]) begin
				rem_q <= trial[pee_pkg::DATA_W-1:0];
			end else begin
				rem_q <= shifted[pee_pkg::DATA_W-1:0];
			end
			quo_q <= {quo_q[pee_pkg::DATA_W-2:0], ~trial[pee_pkg::DATA_W]};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign div_zero = zero_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

[hdl/pee_datapath.sv]
// Datapath: operand stack, operand and result registers, ALU and output word register
`timescale 1ns / 1ps
`include "prefix_expression_evaluator_defines.svh"
module pee_datapath #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pee_pkg::cmd_t              cmd,
	output pee_pkg::sts_t              sts,
	input  logic [pee_pkg::SYM_W-1:0]  symbol,
	input  logic                       last_symbol,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [pee_pkg::DATA_W-1:0] result_value,
	output logic                       stack_was_empty,
	output logic                       divide_by_zero
);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [pee_pkg::SYM_W-1:0]  sym_q;
	logic                       last_q;
	logic [CW-1:0]              count_q;
	logic                       hit_q;
	logic                       err_q;
	logic [pee_pkg::DATA_W-1:0] left_q;
	logic [pee_pkg::DATA_W-1:0] right_q;
	logic [pee_pkg::DATA_W-1:0] alu_q;
	logic                       out_valid_q;
	logic [pee_pkg::DATA_W-1:0] out_value_q;
	logic                       out_empty_q;
	logic                       out_err_q;

	logic                       not_full;
	logic                       not_empty;
	logic                       ram_we;
	logic [pee_pkg::DATA_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [CW-1:0]              top_idx;
	logic [pee_pkg::DATA_W-1:0] ram_rdata;
	logic                       div_busy;
	logic                       div_done;
	logic                       div_zero;
	logic [pee_pkg::DATA_W-1:0] div_quo;
	pee_pkg::op_t               op;

	assign not_full  = (count_q != CW'(STACK_DEPTH));
	assign not_empty = (count_q != '0);
	assign top_idx   = count_q - 1'b1;
	assign op        = pee_pkg::decode_op(sym_q);
	assign ram_we    = (cmd.push_digit || cmd.push_alu) && not_full;
	assign ram_wdata = cmd.push_digit ?
		{{(pee_pkg::DATA_W - pee_pkg::SYM_W){1'b0}}, sym_q - pee_pkg::CHAR_ZERO} : alu_q;
	assign ram_re    = cmd.pop || cmd.read_top;

	pee_ram #(
		.WIDTH(pee_pkg::DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(top_idx[AW-1:0]),
		.rdata(ram_rdata)
	);

	pee_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(left_q),
		.divisor (right_q),
		.busy    (div_busy),
		.done    (div_done),
		.div_zero(div_zero),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.pop && not_empty) begin
				count_q <= top_idx;
			end else if (cmd.emit) begin
				count_q <= '0;
			end
			if (cmd.emit) begin
				err_q <= 1'b0;
			end else if (cmd.cap_div && div_zero) begin
				err_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sym_q  <= symbol;
			last_q <= last_symbol;
		end
		if (cmd.pop) begin
			hit_q <= not_empty;
		end
		if (cmd.cap_left) begin
			left_q <= hit_q ? ram_rdata : pee_pkg::NEG_ONE;
		end
		if (cmd.cap_right) begin
			right_q <= hit_q ? ram_rdata : pee_pkg::NEG_ONE;
		end
		if (cmd.exec) begin
			case (op)
				pee_pkg::OP_ADD: alu_q <= left_q + right_q;
				pee_pkg::OP_SUB: alu_q <= left_q - right_q;
				pee_pkg::OP_MUL: alu_q <= left_q * right_q;
				default:         alu_q <= alu_q;
			endcase
		end else if (cmd.cap_div) begin
			alu_q <= div_quo;
		end
		if (cmd.emit) begin
			out_value_q <= not_empty ? ram_rdata : pee_pkg::INT_MIN;
			out_empty_q <= !not_empty;
			out_err_q   <= err_q;
		end
	end

	assign sts.digit    = pee_pkg::is_digit(sym_q);
	assign sts.op       = op;
	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid    = out_valid_q;
	assign result_value    = out_value_q;
	assign stack_was_empty = out_empty_q;
	assign divide_by_zero  = out_err_q;

	`PEE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(STACK_DEPTH),
		"stack count beyond depth")
	`PEE_ASSERT_NXT(a_emit_clears, clk, arst_n, cmd.emit, count_q == '0 && !err_q,
		"stack not cleared after result")
	`PEE_ASSERT_IMP(a_div_idle, clk, arst_n, cmd.div_start, !div_busy && !div_done,
		"divider started while busy")
endmodule

[hdl/pee_ctrl.sv]
// Controller: sequences decode, pops, operation, push and result per input word
`timescale 1ns / 1ps
`include "prefix_expression_evaluator_defines.svh"
module pee_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          symbol_valid,
	output logic          symbol_stall,
	input  pee_pkg::sts_t sts,
	output pee_pkg::cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POP_L,
		S_POP_R,
		S_EXEC,
		S_DIV,
		S_PUSH,
		S_FINISH,
		S_TOP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (symbol_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: state_q <= sts.digit ? S_FINISH : S_POP_L;
				S_POP_L:  state_q <= S_POP_R;
				S_POP_R:  state_q <= S_EXEC;
				S_EXEC: begin
					unique case (sts.op) inside
						pee_pkg::OP_ADD, pee_pkg::OP_SUB, pee_pkg::OP_MUL: state_q <= S_PUSH;
						pee_pkg::OP_DIV: state_q <= S_DIV;
						default:         state_q <= S_FINISH;
					endcase
				end
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH:   state_q <= S_FINISH;
				S_FINISH: state_q <= sts.last ? S_TOP : S_IDLE;
				S_TOP: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.load_in    = (state_q == S_IDLE) && symbol_valid;
		cmd.push_digit = (state_q == S_DECODE) && sts.digit;
		cmd.pop        = ((state_q == S_DECODE) && !sts.digit) || (state_q == S_POP_L);
		cmd.cap_left   = (state_q == S_POP_L);
		cmd.cap_right  = (state_q == S_POP_R);
		cmd.exec       = (state_q == S_EXEC);
		cmd.div_start  = (state_q == S_EXEC) && (sts.op == pee_pkg::OP_DIV);
		cmd.cap_div    = (state_q == S_DIV) && sts.div_done;
		cmd.push_alu   = (state_q == S_PUSH);
		cmd.read_top   = (state_q == S_FINISH) && sts.last;
		cmd.emit       = (state_q == S_TOP) && sts.out_free;
	end

	assign symbol_stall = (state_q != S_IDLE);

	`PEE_ASSERT_IMP(a_done_in_div, clk, arst_n, sts.div_done, state_q == S_DIV,
		"divider finished outside divide state")
	`PEE_ASSERT_NXT(a_pop_pair, clk, arst_n, state_q == S_POP_L, cmd.cap_right,
		"right operand not captured after left")
endmodule

[hdl/prefix_expression_evaluator.sv]
// Top level of the prefix expression evaluator
//
// Feed the expression one character per input word, last character first,
// with last_symbol set on the first character of the string. A digit pushes
// its value; + - * / pop two operands (empty pop gives -1) and push the
// 32-bit wrapped result; any other character drops both operands.
// One output word follows each word carrying last_symbol: the top of stack
// (or the most negative value with stack_was_empty set) and divide_by_zero.
// Each input word runs through the controller sequence: decode (a digit is
// pushed there), then for any other character the two pops and the operation,
// with a wait on the bit-serial divider and a push for + - * /; a final word
// then waits for a free output register and emits the result. symbol_stall
// stays high until the word is done.
// The output word sits in its own register: while result_stall is high it
// holds, and the block keeps taking and evaluating input until it has the
// next result ready.
// Reset clears the stack count, the error flag and the output valid; the
// stack RAM needs no clearing pass.
`timescale 1ns / 1ps
module prefix_expression_evaluator #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              symbol_valid,
	output logic                              symbol_stall,
	input  logic [pee_pkg::SYM_W-1:0]         symbol,
	input  logic                              last_symbol,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [pee_pkg::DATA_W-1:0] result_value,
	output logic                              stack_was_empty,
	output logic                              divide_by_zero
);
	pee_pkg::cmd_t              cmd;
	pee_pkg::sts_t              sts;
	logic [pee_pkg::DATA_W-1:0] value;

	pee_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.symbol_valid(symbol_valid),
		.symbol_stall(symbol_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	pee_datapath #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.symbol         (symbol),
		.last_symbol    (last_symbol),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_value   (value),
		.stack_was_empty(stack_was_empty),
		.divide_by_zero (divide_by_zero)
	);

	assign result_value = $signed(value);
endmodule

[tb/testbench.sv]
// Self-checking testbench for the prefix expression evaluator
`timescale 1ns / 1ps
module testbench;
	localparam int SYM_W  = pee_pkg::SYM_W;
	localparam int DATA_W = pee_pkg::DATA_W;

	localparam logic [SYM_W-1:0]  CHAR_ZERO  = pee_pkg::CHAR_ZERO;
	localparam logic [SYM_W-1:0]  CHAR_NINE  = pee_pkg::CHAR_NINE;
	localparam logic [SYM_W-1:0]  CHAR_PLUS  = pee_pkg::CHAR_PLUS;
	localparam logic [SYM_W-1:0]  CHAR_MINUS = pee_pkg::CHAR_MINUS;
	localparam logic [SYM_W-1:0]  CHAR_STAR  = pee_pkg::CHAR_STAR;
	localparam logic [SYM_W-1:0]  CHAR_SLASH = pee_pkg::CHAR_SLASH;
	localparam logic [DATA_W-1:0] INT_MIN    = pee_pkg::INT_MIN;
	localparam logic [DATA_W-1:0] NEG_ONE    = pee_pkg::NEG_ONE;

	localparam int DEPTH        = 64;
	localparam int HOLD_CYCLES  = 1500;
	localparam int BATCH_WORDS  = 500;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [SYM_W-1:0] CHAR_X = 8'h78;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             last;
	} symbol_word_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     empty;
		logic                     dbz;
	} evaluation_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     symbol_valid = 1'b0;
	logic                     symbol_stall;
	logic [SYM_W-1:0]         symbol = '0;
	logic                     last_symbol = 1'b0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic                     stack_was_empty;
	logic                     divide_by_zero;

	symbol_word_t pending_symbols[$];
	evaluation_t  expected_evaluations[$];

	logic [DATA_W-1:0] operand_model[DEPTH];
	int                operand_count = 0;
	bit                div_error_seen = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int error_count = 0;
	int results_checked = 0;
	int dbz_results = 0;
	int empty_results = 0;
	int stimulus_words = 0;
	int expressions = 0;

	prefix_expression_evaluator #(
		.STACK_DEPTH(DEPTH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.symbol_valid   (symbol_valid),
		.symbol_stall   (symbol_stall),
		.symbol         (symbol),
		.last_symbol    (last_symbol),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result_value   (result_value),
		.stack_was_empty(stack_was_empty),
		.divide_by_zero (divide_by_zero)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [DATA_W-1:0] quotient_toward_zero(input logic [DATA_W-1:0] num,
		input logic [DATA_W-1:0] den);
		logic [DATA_W-1:0] mag_n, mag_d, q;
		mag_n = num[DATA_W-1] ? -num : num;
		mag_d = den[DATA_W-1] ? -den : den;
		q = mag_n / mag_d;
		return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
	endfunction

	task automatic push_operand(input logic [DATA_W-1:0] v);
		if (operand_count < DEPTH) begin
			operand_model[operand_count] = v;
			operand_count++;
		end
	endtask

	task automatic pop_operand(output logic [DATA_W-1:0] v);
		if (operand_count == 0) begin
			v = NEG_ONE;
		end else begin
			operand_count--;
			v = operand_model[operand_count];
		end
	endtask

	task automatic evaluate_symbol(input symbol_word_t w);
		logic [DATA_W-1:0] lhs, rhs;
		evaluation_t res;
		if (w.sym >= CHAR_ZERO && w.sym <= CHAR_NINE) begin
			push_operand(DATA_W'(w.sym - CHAR_ZERO));
		end else begin
			pop_operand(lhs);
			pop_operand(rhs);
			case (w.sym)
				CHAR_PLUS:  push_operand(lhs + rhs);
				CHAR_MINUS: push_operand(lhs - rhs);
				CHAR_STAR:  push_operand(lhs * rhs);
				CHAR_SLASH: begin
					if (rhs == '0) begin
						div_error_seen = 1'b1;
						push_operand('0);
					end else begin
						push_operand(quotient_toward_zero(lhs, rhs));
					end
				end
				default: ;
			endcase
		end
		if (w.last) begin
			if (operand_count == 0) begin
				res.value = INT_MIN;
				res.empty = 1'b1;
			end else begin
				res.value = operand_model[operand_count - 1];
				res.empty = 1'b0;
			end
			res.dbz = div_error_seen;
			expected_evaluations.push_back(res);
			operand_count = 0;
			div_error_seen = 1'b0;
		end
	endtask

	always @(posedge clk) begin : drive_symbols
		symbol_word_t w;
		bit           send;
		if (arst_n && symbol_valid && !symbol_stall) begin
			w.sym = symbol;
			w.last = last_symbol;
			evaluate_symbol(w);
		end
		if (arst_n && (!symbol_valid || !symbol_stall)) begin
			send = (pending_symbols.size() != 0) && ($urandom_range(99) >= send_idle_pct);
			if (send) begin
				w = pending_symbols.pop_front();
				symbol <= w.sym;
				last_symbol <= w.last;
			end
			symbol_valid <= send;
		end
	end

	always @(posedge clk) begin : check_results
		evaluation_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (expected_evaluations.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result: expected none, got value %0d empty %0b dbz %0b",
					$time, result_value, stack_was_empty, divide_by_zero);
			end else begin
				exp_r = expected_evaluations.pop_front();
				if (exp_r.dbz)
					dbz_results++;
				if (exp_r.empty)
					empty_results++;
				if (result_value !== exp_r.value) begin
					error_count++;
					$display("%0t: result_value mismatch: expected %0d, got %0d",
						$time, exp_r.value, result_value);
				end
				if (stack_was_empty !== exp_r.empty) begin
					error_count++;
					$display("%0t: stack_was_empty mismatch: expected %0b, got %0b",
						$time, exp_r.empty, stack_was_empty);
				end
				if (divide_by_zero !== exp_r.dbz) begin
					error_count++;
					$display("%0t: divide_by_zero mismatch: expected %0b, got %0b",
						$time, exp_r.dbz, divide_by_zero);
				end
			end
		end
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic offer_symbol(input logic [SYM_W-1:0] s, input logic l);
		symbol_word_t w;
		w.sym = s;
		w.last = l;
		pending_symbols.push_back(w);
		stimulus_words++;
		if (l)
			expressions++;
	endtask

	function automatic logic [SYM_W-1:0] pick_digit();
		return CHAR_ZERO + SYM_W'($urandom_range(9));
	endfunction

	function automatic logic [SYM_W-1:0] pick_operator();
		logic [SYM_W-1:0] s;
		case ($urandom_range(9))
			0, 1:    s = CHAR_PLUS;
			2, 3:    s = CHAR_MINUS;
			4, 5:    s = CHAR_STAR;
			6, 7, 8: s = CHAR_SLASH;
			default: begin
				s = SYM_W'($urandom_range(255));
				if (s >= CHAR_ZERO && s <= CHAR_NINE)
					s = CHAR_X;
			end
		endcase
		return s;
	endfunction

	task automatic offer_expression(input int n_ops);
		int digits_left, ops_left, depth;
		logic [SYM_W-1:0] s;
		digits_left = n_ops + 1;
		ops_left = n_ops;
		depth = 0;
		while (digits_left + ops_left > 0) begin
			if (depth >= 2 && ops_left > 0 && (digits_left == 0 || $urandom_range(1))) begin
				s = pick_operator();
				depth--;
				ops_left--;
			end else begin
				s = pick_digit();
				depth++;
				digits_left--;
			end
			offer_symbol(s, digits_left + ops_left == 0);
		end
	endtask

	task automatic offer_deep_stack(input int n_push);
		int n_ops;
		n_ops = $urandom_range(4);
		for (int i = 0; i < n_push; i++)
			offer_symbol(pick_digit(), n_ops == 0 && i == n_push - 1);
		for (int i = 0; i < n_ops; i++)
			offer_symbol(pick_operator(), i == n_ops - 1);
	endtask

	// 2 * 8^10 wraps to the most negative value; the final operator pops minus one
	task automatic offer_power_chain(input logic [SYM_W-1:0] final_op);
		offer_symbol(CHAR_ZERO + 8'd2, 1'b0);
		repeat (10) begin
			offer_symbol(CHAR_ZERO + 8'd8, 1'b0);
			offer_symbol(CHAR_STAR, 1'b0);
		end
		offer_symbol(final_op, 1'b1);
	endtask

	task automatic offer_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			offer_symbol(SYM_W'($urandom_range(255)), i == n - 1);
	endtask

	task automatic offer_random_batch(input int words);
		int target, pick;
		target = stimulus_words + words;
		while (stimulus_words < target) begin
			pick = $urandom_range(99);
			if (pick < 72)
				offer_expression($urandom_range(10));
			else if (pick < 80)
				offer_expression($urandom_range(11, 40));
			else if (pick < 82)
				offer_deep_stack($urandom_range(DEPTH - 4, DEPTH + 8));
			else if (pick < 85)
				offer_power_chain(pick_operator());
			else
				offer_noise();
		end
	endtask

	task automatic wait_for_drain();
		while (pending_symbols.size() != 0 || symbol_valid || expected_evaluations.size() != 0)
			@(negedge clk);
	endtask

	initial begin : run_phases
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 30;
		recv_idle_pct = 82;
		offer_symbol(CHAR_ZERO, 1'b1);
		offer_symbol(CHAR_NINE, 1'b1);
		// operator on an empty stack
		offer_symbol(CHAR_PLUS, 1'b1);
		// lone unknown characters leave nothing on the stack
		offer_symbol(8'hFF, 1'b1);
		offer_symbol(8'h00, 1'b1);
		// (7 + ((9 - 4) * (8 / 3)))
		offer_symbol(CHAR_ZERO + 8'd3, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd8, 1'b0);
		offer_symbol(CHAR_SLASH, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd4, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd9, 1'b0);
		offer_symbol(CHAR_MINUS, 1'b0);
		offer_symbol(CHAR_STAR, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd7, 1'b0);
		offer_symbol(CHAR_PLUS, 1'b1);
		// divide by zero
		offer_symbol(CHAR_ZERO, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd5, 1'b0);
		offer_symbol(CHAR_SLASH, 1'b1);
		// unknown operator drops two operands
		offer_symbol(CHAR_ZERO + 8'd1, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd2, 1'b0);
		offer_symbol(CHAR_ZERO + 8'd3, 1'b0);
		offer_symbol(CHAR_X, 1'b1);
		offer_power_chain(CHAR_SLASH);
		offer_deep_stack(DEPTH + 2);
		offer_random_batch(BATCH_WORDS);
		wait_for_drain();

		send_idle_pct = 82;
		recv_idle_pct = 30;
		offer_random_batch(BATCH_WORDS);
		wait_for_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_requests++;
		offer_random_batch(BATCH_WORDS);
		wait_for_drain();

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("run covered %0d words in %0d expressions, %0d results checked",
			stimulus_words, expressions, results_checked);
		$display("of those, %0d saw a division by zero and %0d ended on an empty stack",
			dbz_results, empty_results);
		if (error_count == 0 && expected_evaluations.size() == 0) begin
			$display("prefix_expression_evaluator regression: pass");
		end else begin
			$display("prefix_expression_evaluator regression: fail");
		end
		$finish;
	end

	initial begin : watchdog
		#12_000_000;
		$display("prefix_expression_evaluator regression: fail");
		$finish;
	end
endmodule
